>>> hdl/sobel_edge_stream_top_macros.svh
// Assertion macros for the Sobel edge stream block.
`ifndef SOBEL_EDGE_STREAM_TOP_MACROS_SVH
`define SOBEL_EDGE_STREAM_TOP_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SES_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define SES_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> hdl/ses_pkg.sv
// Shared types, constants and arithmetic helpers of the Sobel edge stream block.
package ses_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MIN_DIM    = 3;

	localparam int PIX_W     = 8;
	localparam int DIM_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int GRAD_W    = PIX_W + 3;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_HEIGHT);
	localparam int DIMX_W    = $clog2(MAX_WIDTH + 1);
	localparam int DIMY_W    = $clog2(MAX_HEIGHT + 1);
	localparam int PIX_MAX   = (1 << PIX_W) - 1;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef struct packed {
		pixel_t top;
		pixel_t mid;
		pixel_t bot;
	} col_t;

	typedef logic signed [GRAD_W-1:0] grad_t;

	function automatic int clamp_dim(logic [DIM_W-1:0] v, int hi);
		if (int'(v) < MIN_DIM) return MIN_DIM;
		if (int'(v) > hi) return hi;
		return int'(v);
	endfunction

	function automatic pixel_t clamp_byte(grad_t g);
		if (g < 0) return '0;
		if (g > PIX_MAX) return '1;
		return g[PIX_W-1:0];
	endfunction

	function automatic pixel_t sat_sum(pixel_t a, pixel_t b);
		logic [PIX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[PIX_W] ? '1 : s[PIX_W-1:0];
	endfunction

endpackage

>>> hdl/ses_kernel.sv
// Horizontal and vertical 3x3 Sobel gradients over one window.
module ses_kernel (
	input  ses_pkg::col_t  left,
	input  ses_pkg::col_t  center,
	input  ses_pkg::col_t  right,
	output ses_pkg::grad_t gx,
	output ses_pkg::grad_t gy
);

	ses_pkg::grad_t t0, m0, b0, t1, b1, t2, m2, b2;

	assign t0 = $signed(ses_pkg::GRAD_W'(left.top));
	assign m0 = $signed(ses_pkg::GRAD_W'(left.mid));
	assign b0 = $signed(ses_pkg::GRAD_W'(left.bot));
	assign t1 = $signed(ses_pkg::GRAD_W'(center.top));
	assign b1 = $signed(ses_pkg::GRAD_W'(center.bot));
	assign t2 = $signed(ses_pkg::GRAD_W'(right.top));
	assign m2 = $signed(ses_pkg::GRAD_W'(right.mid));
	assign b2 = $signed(ses_pkg::GRAD_W'(right.bot));

	assign gx = (t2 - t0) + ((m2 - m0) <<< 1) + (b2 - b0);
	assign gy = (b0 - t0) + ((b1 - t1) <<< 1) + (b2 - t2);

endmodule

>>> hdl/sobel_edge_stream_top.sv
// Sobel edge detector over a raster pixel stream: one pixel a clock unless the
// output stalls, one edge value per interior pixel. Both line stores share one
// 16-bit wide memory with MAX_WIDTH entries and a registered read port; the
// accept cycle reads the column, written back shifted by one row when the beat
// leaves stage s1. Entries never written since reset read as zero through a
// fill mark, so no clearing pass runs after reset. Results start at row 2,
// column 2 of each frame; tlast marks the frame's final result. Any register
// write restarts the frame at row 0, column 0, keeping the line stores.
module sobel_edge_stream_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ses_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ses_pkg::DIM_W-1:0]         cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // [7:0] pixel_in
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,  // [7:0] edge_value
	output logic                              m_tlast   // frame_last
);

	logic [ses_pkg::DIM_W-1:0]  width_q, height_q;
	logic [ses_pkg::DIMX_W-1:0] w_eff, fill_q;
	logic [ses_pkg::DIMY_W-1:0] h_eff;
	logic [ses_pkg::COL_W-1:0]  col_q;
	logic [ses_pkg::ROW_W-1:0]  row_q;
	logic                       last_col, last_row, hit;

	logic [2*ses_pkg::PIX_W-1:0] line_mem [ses_pkg::MAX_WIDTH];
	logic [2*ses_pkg::PIX_W-1:0] rd_s1;

	logic                      s1_valid, prod_s1, last_s1, hit_s1;
	ses_pkg::pixel_t           pix_s1;
	logic [ses_pkg::COL_W-1:0] col_s1;
	ses_pkg::col_t             win0_q, win1_q, new_col;

	logic           s2_valid, last_s2;
	ses_pkg::grad_t gx, gy, gx_s2, gy_s2;

	logic           out_valid_q, out_last_q;
	ses_pkg::pixel_t out_data_q;

	logic s_acc, out_free, s2_free, s2_adv, s1_adv;

	assign w_eff = ses_pkg::DIMX_W'(ses_pkg::clamp_dim(width_q, ses_pkg::MAX_WIDTH));
	assign h_eff = ses_pkg::DIMY_W'(ses_pkg::clamp_dim(height_q, ses_pkg::MAX_HEIGHT));

	assign last_col = (ses_pkg::DIMX_W'(col_q) + 1'b1) == w_eff;
	assign last_row = (ses_pkg::DIMY_W'(row_q) + 1'b1) == h_eff;
	assign hit      = ses_pkg::DIMX_W'(col_q) < fill_q;

	assign out_free = !out_valid_q || m_tready;
	assign s2_free  = !s2_valid || out_free;
	assign s2_adv   = s2_valid && out_free;
	assign s1_adv   = s1_valid && (s2_free || !prod_s1);
	assign s_tready = !s1_valid || s1_adv;
	assign s_acc    = s_tvalid && s_tready;

	// frame position, registers and fill mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ses_pkg::WIDTH_RESET;
			height_q <= ses_pkg::HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
			fill_q   <= '0;
		end else if (cfg_we) begin
			case (ses_pkg::cfg_idx_t'(cfg_index))
				ses_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_data;
				ses_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (s_acc) begin
			if (!hit) begin
				fill_q <= fill_q + 1'b1;
			end
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// line store memory: entry holds {newer row, older row}
	always_ff @(posedge clk) begin
		if (s_acc) begin
			rd_s1 <= line_mem[col_q];
		end
		if (s1_adv) begin
			line_mem[col_s1] <= {new_col.bot, new_col.mid};
		end
	end

	assign new_col.top = hit_s1 ? rd_s1[ses_pkg::PIX_W-1:0] : '0;
	assign new_col.mid = hit_s1 ? rd_s1[2*ses_pkg::PIX_W-1:ses_pkg::PIX_W] : '0;
	assign new_col.bot = pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_acc) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			pix_s1  <= s_tdata;
			col_s1  <= col_q;
			hit_s1  <= hit;
			prod_s1 <= (row_q >= ses_pkg::ROW_W'(2)) && (col_q >= ses_pkg::COL_W'(2));
			last_s1 <= last_row && last_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q <= '0;
			win1_q <= '0;
		end else if (s1_adv) begin
			win0_q <= win1_q;
			win1_q <= new_col;
		end
	end

	ses_kernel u_kernel (
		.left   (win0_q),
		.center (win1_q),
		.right  (new_col),
		.gx     (gx),
		.gy     (gy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s1_adv && prod_s1) begin
			s2_valid <= 1'b1;
		end else if (s2_adv) begin
			s2_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && prod_s1) begin
			gx_s2   <= gx;
			gy_s2   <= gy;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			out_data_q <= ses_pkg::sat_sum(ses_pkg::clamp_byte(gx_s2),
				ses_pkg::clamp_byte(gy_s2));
			out_last_q <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

>>> hdl/ses_checker.sv
// Port-level checks of the Sobel edge stream block and their bind.
`include "sobel_edge_stream_top_macros.svh"

module ses_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// saturating count of accepted pixels since reset
	logic [3:0] acc_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_cnt_q <= '0;
		end else if (s_tvalid && s_tready && acc_cnt_q != 4'hf) begin
			acc_cnt_q <= acc_cnt_q + 1'b1;
		end
	end

	`SES_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result beat changed while stalled")
	`SES_ASSERT(a_in_ready, !m_tvalid || m_tready |-> s_tready, "input stalled with output free")
	`SES_NEVER(a_early_out, m_tvalid && acc_cnt_q < 4'd9, "result before a full 3x3 window")

endmodule

bind sobel_edge_stream_top ses_checker u_ses_checker (.*);

>>> tb/tb_sobel_edge_stream_top.sv
// Testbench for the Sobel edge stream block: directed frames, then random frames vs. a predictor.
`timescale 1ns / 1ps

module tb_sobel_edge_stream_top;
	import ses_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int SETTLE_CYC   = 8;
	localparam int RAND_ITEMS   = 1950;
	localparam int DIR_N        = 34;
	localparam int TALL_ROWS    = 64;

	typedef struct packed {
		pixel_t edge_value;
		logic   frame_last;
	} edge_res_t;

	typedef struct packed {
		logic             is_cfg;
		cfg_idx_t         idx;
		logic [DIM_W-1:0] value;
		pixel_t           pix;
		logic             typed;
		pixel_t           exp_edge;
		logic             exp_last;
	} dir_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0]     cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [7:0]           m_tdata;
	logic                 m_tlast;

	// predictor state
	pixel_t           row_older [MAX_WIDTH];
	pixel_t           row_newer [MAX_WIDTH];
	pixel_t           win [6];
	int               col_pos;
	int               row_pos;
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;

	edge_res_t edge_q [$];
	edge_res_t rcv_exp;
	dir_row_t  dir_tab [DIR_N];
	int        err_cnt  = 0;
	int        idle_cnt = 0;
	int        rcv_wait = 0;
	bit        snd_calm = 1'b0;
	bit        rcv_calm = 1'b0;
	pixel_t    prev_pix = '0;

	sobel_edge_stream_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int fit_dim(logic [DIM_W-1:0] v, int hi);
		if (int'(v) < MIN_DIM) return MIN_DIM;
		if (int'(v) > hi) return hi;
		return int'(v);
	endfunction

	function automatic int sat8(int v);
		if (v < 0) return 0;
		if (v > 255) return 255;
		return v;
	endfunction

	function automatic bit sobel_predict(pixel_t p, output edge_res_t res);
		int     w, h, c, r, gx, gy, sum;
		pixel_t top, mid;
		bit     has;
		w = fit_dim(width_reg, MAX_WIDTH);
		h = fit_dim(height_reg, MAX_HEIGHT);
		c = col_pos;
		r = row_pos;
		if (c >= w) c = 0;
		if (r >= h) r = 0;
		top = row_older[c];
		mid = row_newer[c];
		has = 1'b0;
		res = '0;
		if (r >= 2 && c >= 2) begin
			gx = (int'(top) - int'(win[0])) + 2 * (int'(mid) - int'(win[1]))
				+ (int'(p) - int'(win[2]));
			gy = (int'(win[2]) + 2 * int'(win[5]) + int'(p))
				- (int'(win[0]) + 2 * int'(win[3]) + int'(top));
			sum = sat8(gx) + sat8(gy);
			if (sum > 255) sum = 255;
			res.edge_value = pixel_t'(sum);
			res.frame_last = (r == h - 1) && (c == w - 1);
			has = 1'b1;
		end
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = top;
		win[4] = mid;
		win[5] = p;
		row_older[c] = mid;
		row_newer[c] = p;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		col_pos = c;
		row_pos = r;
		return has;
	endfunction

	function automatic pixel_t draw_pixel();
		int d;
		case ($urandom_range(0, 7))
			0: prev_pix = '0;
			1: prev_pix = '1;
			2, 3, 4: prev_pix = pixel_t'($urandom_range(0, 255));
			default: begin
				d = $urandom_range(0, 16);
				prev_pix = pixel_t'(int'(prev_pix) + d - 8);
			end
		endcase
		return prev_pix;
	endfunction

	task automatic send_pixel(pixel_t p, logic typed, edge_res_t typed_res);
		int        gap;
		edge_res_t res;
		bit        has;
		if ($urandom_range(0, 63) == 0) snd_calm = !snd_calm;
		gap = snd_calm ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= p;
		do @(posedge clk); while (!s_tready);
		has = sobel_predict(p, res);
		if (typed) edge_q.push_back(typed_res);
		else if (has) edge_q.push_back(res);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (edge_q.size() != 0);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [DIM_W-1:0] val);
		drain_results();
		// border beats may still be in the pipe
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FRAME_WIDTH) width_reg = val;
		else height_reg = val;
		col_pos = 0;
		row_pos = 0;
		@(posedge clk);
	endtask

	// result side: random stalls, compare each beat with the oldest prediction
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (edge_q.size() == 0) begin
				$error("unexpected result: edge_value %0d frame_last %0d", m_tdata, m_tlast);
				err_cnt++;
			end else begin
				rcv_exp = edge_q.pop_front();
				if (m_tdata !== rcv_exp.edge_value) begin
					$error("edge_value: expected %0d, actual %0d", rcv_exp.edge_value, m_tdata);
					err_cnt++;
				end
				if (m_tlast !== rcv_exp.frame_last) begin
					$error("frame_last: expected %0d, actual %0d", rcv_exp.frame_last, m_tlast);
					err_cnt++;
				end
			end
			if ($urandom_range(0, 63) == 0) rcv_calm = !rcv_calm;
			rcv_wait = rcv_calm ? 0 : $urandom_range(0, 16);
			if (rcv_wait != 0) m_tready <= 1'b0;
		end else if (!m_tready && arst_n) begin
			if (rcv_wait == 0) m_tready <= 1'b1;
			else rcv_wait--;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cnt <= 0;
		end else if (idle_cnt >= IDLE_LIMIT) begin
			$display("[sobel_edge_stream_top] ERROR");
			$finish;
		end else begin
			idle_cnt <= idle_cnt + 1;
		end
	end

	initial begin
		int               n_items, phase, n_px, w_eff, h_eff;
		bit               wr_w, wr_h;
		logic [DIM_W-1:0] wv, hv;
		edge_res_t        tr;

		width_reg  = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		foreach (row_older[i]) row_older[i] = '0;
		foreach (row_newer[i]) row_newer[i] = '0;
		foreach (win[i]) win[i] = '0;
		col_pos = 0;
		row_pos = 0;

		dir_tab = '{
			// 3x3, dark top rows, bright bottom row: vertical gradient saturates
			'{1'b1, CFG_FRAME_WIDTH,  11'd3, 8'd0,   1'b0, 8'd0,   1'b0},
			'{1'b1, CFG_FRAME_HEIGHT, 11'd3, 8'd0,   1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd0,   1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd0,   1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd0,   1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd0,   1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd0,   1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd0,   1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd255, 1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd255, 1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd255, 1'b1, 8'd255, 1'b1},
			// undersized registers clamp to 3; negative gradient gives zero
			'{1'b1, CFG_FRAME_WIDTH,  11'd0, 8'd0,   1'b0, 8'd0,   1'b0},
			'{1'b1, CFG_FRAME_HEIGHT, 11'd2, 8'd0,   1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd255, 1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd255, 1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd255, 1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd255, 1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd255, 1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd255, 1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd0,   1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd0,   1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd0,   1'b1, 8'd0,   1'b1},
			// partial frame, then a rewrite restarts at row 0, column 0
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd99,  1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd99,  1'b0, 8'd0,   1'b0},
			'{1'b1, CFG_FRAME_HEIGHT, 11'd3, 8'd0,   1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd10,  1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd200, 1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd30,  1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd250, 1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd0,   1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd99,  1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd1,   1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd128, 1'b0, 8'd0,   1'b0},
			'{1'b0, CFG_FRAME_WIDTH,  11'd0, 8'd254, 1'b0, 8'd0,   1'b0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				write_reg(dir_tab[i].idx, dir_tab[i].value);
			end else begin
				tr.edge_value = dir_tab[i].exp_edge;
				tr.frame_last = dir_tab[i].exp_last;
				send_pixel(dir_tab[i].pix, dir_tab[i].typed, tr);
			end
		end

		n_items = 0;
		phase   = 0;
		while (n_items < RAND_ITEMS) begin
			if (phase == 2) begin
				// widest row, raw value at or above the limit; one row and a bit
				case ($urandom_range(0, 2))
					0: wv = DIM_W'(1024);
					1: wv = DIM_W'(1025);
					default: wv = DIM_W'(2047);
				endcase
				hv   = DIM_W'(3);
				n_px = MAX_WIDTH + 32;
			end else if (phase == 5) begin
				// top of a tall frame, height from a raw value at or above the limit
				wv   = DIM_W'(3);
				hv   = DIM_W'($urandom_range(1024, 2047));
				n_px = 3 * TALL_ROWS;
			end else begin
				if ($urandom_range(0, 7) == 0) begin
					wv = DIM_W'($urandom_range(0, 2));
					hv = DIM_W'($urandom_range(0, 2));
				end else begin
					wv = DIM_W'($urandom_range(3, 12));
					hv = DIM_W'($urandom_range(3, 8));
				end
				w_eff = fit_dim(wv, MAX_WIDTH);
				h_eff = fit_dim(hv, MAX_HEIGHT);
				if ($urandom_range(0, 3) == 0) n_px = $urandom_range(1, 2 * w_eff * h_eff);
				else n_px = w_eff * h_eff * $urandom_range(1, 3);
			end
			if (n_px > RAND_ITEMS - n_items) n_px = RAND_ITEMS - n_items;
			wr_w = (wv != width_reg) || ($urandom_range(0, 1) == 1);
			wr_h = (hv != height_reg) || ($urandom_range(0, 1) == 1);
			if (!wr_w && !wr_h) wr_w = 1'b1;
			if (wr_w) write_reg(CFG_FRAME_WIDTH, wv);
			if (wr_h) write_reg(CFG_FRAME_HEIGHT, hv);
			repeat (n_px) begin
				if ($urandom_range(0, 299) == 0) drain_results();
				send_pixel(draw_pixel(), 1'b0, '0);
			end
			n_items += n_px;
			phase++;
		end

		drain_results();
		repeat (16) @(posedge clk);
		if (err_cnt == 0) begin
			$display("[sobel_edge_stream_top] OK");
		end else begin
			$display("[sobel_edge_stream_top] ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ses_pkg.sv
hdl/ses_kernel.sv
hdl/sobel_edge_stream_top.sv
hdl/ses_checker.sv
tb/tb_sobel_edge_stream_top.sv
